// ===== hdl/ftt_pkg.sv =====
// shared types, constants and character classification for the format text tokenizer
`default_nettype none
package ftt_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] LimitReset = 8'd255;

  localparam logic [CharW-1:0] ChPercent = 8'h25;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChTab     = 8'h09;
  localparam logic [CharW-1:0] ChCr      = 8'h0d;
  localparam logic [CharW-1:0] ChNul     = 8'h00;

  typedef enum logic [4:0] {
    TK_INPUT         = 5'd0,
    TK_OUTPUT        = 5'd1,
    TK_CLASS         = 5'd2,
    TK_IN_DIM        = 5'd3,
    TK_OUT_DIM       = 5'd4,
    TK_NUM_PATTERNS  = 5'd5,
    TK_ASTERISK      = 5'd6,
    TK_QUESTION      = 5'd7,
    TK_NEWLINE       = 5'd8,
    TK_WRITE_NEWLINE = 5'd9,
    TK_ALT_BEGIN     = 5'd10,
    TK_ALT_END       = 5'd11,
    TK_LOOP_BEGIN    = 5'd12,
    TK_LOOP_END      = 5'd13,
    TK_BAR           = 5'd14,
    TK_STRING_CHAR   = 5'd15,
    TK_STRING_END    = 5'd16,
    TK_END_OF_TEXT   = 5'd17,
    TK_UNKNOWN       = 5'd18,
    TK_NONE          = 5'd31
  } token_kind_e;

  // one queue entry: the results caused by one input item
  typedef struct packed {
    logic             has_two;
    token_kind_e      kind0;
    logic [CharW-1:0] val0;
    token_kind_e      kind1;
  } entry_t;

  function automatic token_kind_e structural_kind(input logic [CharW-1:0] c);
    token_kind_e k;
    case (c)
      8'h5b:   k = TK_ALT_BEGIN;
      8'h5d:   k = TK_ALT_END;
      8'h7b:   k = TK_LOOP_BEGIN;
      8'h7d:   k = TK_LOOP_END;
      8'h7c:   k = TK_BAR;
      8'h2a:   k = TK_ASTERISK;
      8'h3f:   k = TK_QUESTION;
      8'h3c:   k = TK_NEWLINE;
      8'h5c:   k = TK_WRITE_NEWLINE;
      ChNul:   k = TK_END_OF_TEXT;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

  function automatic token_kind_e control_kind(input logic [CharW-1:0] c);
    token_kind_e k;
    logic [CharW-1:0] u;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c - 8'd32;
    end
    case (u)
      8'h49:   k = TK_INPUT;
      8'h4f:   k = TK_OUTPUT;
      8'h43:   k = TK_CLASS;
      8'h45:   k = TK_IN_DIM;
      8'h41:   k = TK_OUT_DIM;
      8'h4e:   k = TK_NUM_PATTERNS;
      default: k = TK_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == ChSpace) || (c >= ChTab && c <= ChCr);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/format_text_tokenizer_unit.sv =====
// top level of the format text tokenizer: front end, entry queue and back end
//
//  channel   direction  handshake               payload
//  input     in         push / full             char_code_i
//  result    out        empty / pop             token_kind_o, char_value_o, last_of_run_o
//  config    in         cfg_we_i                cfg_wdata_i (string chunk limit)
//
// one character is accepted per cycle whenever the four-entry queue has room
// each accepted character is classified and its state updated in the same cycle
// the back end delivers one result item per cycle while results are popped; a character
//   with two results holds the back end for both items, the queue absorbs the difference
// a result passes from the queue into the output register before it appears on the ports
// reset clears the tokenizer state, the queue and the output valid flag; the
//   chunk limit resets to 255
`default_nettype none
module format_text_tokenizer_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [ftt_pkg::CharW-1:0]  cfg_wdata_i,
  // character items
  input  wire logic                       push,
  output      logic                       full,
  input  wire logic [ftt_pkg::CharW-1:0]  char_code_i,
  // result items
  output      logic                       empty,
  input  wire logic                       pop,
  output      logic [4:0]                 token_kind_o,
  output      logic [ftt_pkg::CharW-1:0]  char_value_o,
  output      logic                       last_of_run_o
);

  logic            accept;
  logic            emit;
  ftt_pkg::entry_t entry;
  logic            head_valid;
  ftt_pkg::entry_t head;
  logic            head_rd;

  // an item enters when the queue has room, even if it causes no result
  assign accept = push && !full;

  ftt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .char_code_i (char_code_i),
    .emit_o      (emit),
    .entry_o     (entry)
  );

  ftt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept && emit),
    .wr_entry_i (entry),
    .full_o     (full),
    .rd_i       (head_rd),
    .valid_o    (head_valid),
    .rd_entry_o (head)
  );

  ftt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .head_rd_o     (head_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .token_kind_o  (token_kind_o),
    .char_value_o  (char_value_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

// ===== hdl/ftt_front.sv =====
// front end: classifies each character, keeps tokenizer state, builds queue entries
`default_nettype none
module ftt_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ftt_pkg::CharW-1:0]   cfg_wdata_i,
  input  wire logic                        accept_i,
  input  wire logic [ftt_pkg::CharW-1:0]   char_code_i,
  output      logic                        emit_o,
  output      ftt_pkg::entry_t             entry_o
);

  logic [ftt_pkg::CharW-1:0] limit_val_q;
  logic                      pct_q, pct_d;
  logic                      open_q, open_d;
  logic [ftt_pkg::CharW-1:0] cnt_q, cnt_d;

  logic [ftt_pkg::CharW-1:0] lim;
  logic [ftt_pkg::CharW-1:0] cnt_inc;
  ftt_pkg::token_kind_e      s_kind;
  ftt_pkg::token_kind_e      c_kind;
  logic                      escapable;

  // limit of zero acts as one
  assign lim     = (limit_val_q == '0) ? ftt_pkg::CharW'(1) : limit_val_q;
  assign cnt_inc = cnt_q + ftt_pkg::CharW'(1);
  assign s_kind  = ftt_pkg::structural_kind(char_code_i);
  assign c_kind  = ftt_pkg::control_kind(char_code_i);
  assign escapable = (char_code_i == ftt_pkg::ChPercent) ||
                     ((char_code_i != ftt_pkg::ChNul) && (s_kind != ftt_pkg::TK_NONE));

  always_comb begin
    pct_d           = pct_q;
    open_d          = open_q;
    cnt_d           = cnt_q;
    emit_o          = 1'b0;
    entry_o.has_two = 1'b0;
    entry_o.kind0   = ftt_pkg::TK_STRING_CHAR;
    entry_o.val0    = char_code_i;
    entry_o.kind1   = ftt_pkg::TK_STRING_END;
    if (pct_q && !escapable) begin
      pct_d  = 1'b0;
      emit_o = 1'b1;
      if (c_kind != ftt_pkg::TK_NONE) begin
        // control token, closing any open string first
        entry_o.has_two = open_q;
        entry_o.kind0   = open_q ? ftt_pkg::TK_STRING_END : c_kind;
        entry_o.val0    = '0;
        entry_o.kind1   = c_kind;
      end else begin
        // unknown control abandons the string
        entry_o.kind0 = ftt_pkg::TK_UNKNOWN;
      end
      open_d = 1'b0;
      cnt_d  = '0;
    end else if (!pct_q && char_code_i == ftt_pkg::ChPercent) begin
      pct_d = 1'b1;
    end else if (!pct_q && s_kind != ftt_pkg::TK_NONE) begin
      emit_o          = 1'b1;
      entry_o.has_two = open_q;
      entry_o.kind0   = open_q ? ftt_pkg::TK_STRING_END : s_kind;
      entry_o.val0    = '0;
      entry_o.kind1   = s_kind;
      open_d          = 1'b0;
      cnt_d           = '0;
    end else if (!pct_q && !open_q && ftt_pkg::is_space(char_code_i)) begin
      // leading whitespace dropped
    end else begin
      // string character, plain or escaped
      pct_d  = 1'b0;
      emit_o = 1'b1;
      if (cnt_inc >= lim) begin
        entry_o.has_two = 1'b1;
        open_d          = 1'b0;
        cnt_d           = '0;
      end else begin
        open_d = 1'b1;
        cnt_d  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_val_q <= ftt_pkg::LimitReset;
      pct_q       <= 1'b0;
      open_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_val_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        pct_q  <= pct_d;
        open_q <= open_d;
        cnt_q  <= cnt_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ftt_queue.sv =====
// entry queue between the front end and the back end
`default_nettype none
module ftt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire ftt_pkg::entry_t  wr_entry_i,
  output      logic             full_o,
  input  wire logic             rd_i,
  output      logic             valid_o,
  output      ftt_pkg::entry_t  rd_entry_o
);

  ftt_pkg::entry_t                 mem_q [ftt_pkg::QueueDepth];
  logic [ftt_pkg::QueuePtrW-1:0]   wptr_q, rptr_q;
  logic [ftt_pkg::QueueCntW-1:0]   cnt_q;

  assign full_o     = (cnt_q == ftt_pkg::QueueCntW'(ftt_pkg::QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign rd_entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + ftt_pkg::QueuePtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= rptr_q + ftt_pkg::QueuePtrW'(1);
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + ftt_pkg::QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - ftt_pkg::QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ftt_back.sv =====
// back end: splits queue entries into single result items in an output register
`default_nettype none
module ftt_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       head_valid_i,
  input  wire ftt_pkg::entry_t            head_i,
  output      logic                       head_rd_o,
  input  wire logic                       pop_i,
  output      logic                       empty_o,
  output      logic [4:0]                 token_kind_o,
  output      logic [ftt_pkg::CharW-1:0]  char_value_o,
  output      logic                       last_of_run_o
);

  logic                      out_valid_q;
  logic                      phase_q;
  logic                      load;
  ftt_pkg::token_kind_e      kind_q, kind_d;
  logic [ftt_pkg::CharW-1:0] val_q, val_d;
  logic                      last_q, last_d;

  assign load      = head_valid_i && (!out_valid_q || pop_i);
  assign head_rd_o = load && (phase_q || !head_i.has_two);

  always_comb begin
    if (phase_q) begin
      kind_d = head_i.kind1;
      val_d  = '0;
      last_d = 1'b1;
    end else begin
      kind_d = head_i.kind0;
      val_d  = head_i.val0;
      last_d = !head_i.has_two;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        phase_q     <= !phase_q && head_i.has_two;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      val_q  <= val_d;
      last_q <= last_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign token_kind_o  = 5'(kind_q);
  assign char_value_o  = val_q;
  assign last_of_run_o = last_q;

endmodule
`default_nettype wire

// ===== test/format_text_tokenizer_unit_test.sv =====
// testbench for the format text tokenizer: directed text table, then random text against a predictor
`timescale 1ns / 100ps
module format_text_tokenizer_unit_test;

  // structural characters
  localparam logic [7:0] ChLBracket = 8'h5b;
  localparam logic [7:0] ChRBracket = 8'h5d;
  localparam logic [7:0] ChLBrace   = 8'h7b;
  localparam logic [7:0] ChRBrace   = 8'h7d;
  localparam logic [7:0] ChBar      = 8'h7c;
  localparam logic [7:0] ChStar     = 8'h2a;
  localparam logic [7:0] ChQuest    = 8'h3f;
  localparam logic [7:0] ChLess     = 8'h3c;
  localparam logic [7:0] ChBslash   = 8'h5c;
  // control letters, upper case
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChO = 8'h4f;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChA = 8'h41;
  localparam logic [7:0] ChN = 8'h4e;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7a;
  localparam logic [7:0] CaseBit  = 8'h20;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned LongHold      = 120;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseChars    = 200;

  typedef struct packed {
    ftt_pkg::token_kind_e kind;
    logic [7:0]           val;
    logic                 last;
  } token_t;

  // one line of the directed text: a char (with an optional typed answer) or a limit write
  typedef struct packed {
    logic                 is_cfg;
    logic [7:0]           value;
    logic                 typed;
    logic [1:0]           n;
    ftt_pkg::token_kind_e k0;
    logic [7:0]           v0;
    ftt_pkg::token_kind_e k1;
  } text_row_t;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       push      = 1'b0;
  logic [7:0] char_code = 8'd0;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [4:0] token_kind;
  logic [7:0] char_value;
  logic       last_of_run;

  format_text_tokenizer_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .push         (push),
    .full         (full),
    .char_code_i  (char_code),
    .empty        (empty),
    .pop          (pop),
    .token_kind_o (token_kind),
    .char_value_o (char_value),
    .last_of_run_o(last_of_run)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // tokenizer state as the predictor sees it
  logic [7:0]           chunk_limit   = ftt_pkg::LimitReset;
  logic                 after_percent = 1'b0;
  logic                 in_string     = 1'b0;
  logic [7:0]           string_len    = 8'd0;
  ftt_pkg::token_kind_e pred_kind [2];
  logic [7:0]           pred_val [2];
  int                   pred_n;

  token_t    tokens_due [$];     // tokens still owed by the block, oldest first
  text_row_t typed_answers [$];  // directed rows in flight, one per char sent
  text_row_t directed_text [$];
  int        errors      = 0;
  int        chars_sent  = 0;
  int        idle_cycles = 0;
  bit        calm          = 1'b0;
  bit        long_hold_req = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic ftt_pkg::token_kind_e punct_kind(input logic [7:0] c);
    case (c)
      ChLBracket:     return ftt_pkg::TK_ALT_BEGIN;
      ChRBracket:     return ftt_pkg::TK_ALT_END;
      ChLBrace:       return ftt_pkg::TK_LOOP_BEGIN;
      ChRBrace:       return ftt_pkg::TK_LOOP_END;
      ChBar:          return ftt_pkg::TK_BAR;
      ChStar:         return ftt_pkg::TK_ASTERISK;
      ChQuest:        return ftt_pkg::TK_QUESTION;
      ChLess:         return ftt_pkg::TK_NEWLINE;
      ChBslash:       return ftt_pkg::TK_WRITE_NEWLINE;
      ftt_pkg::ChNul: return ftt_pkg::TK_END_OF_TEXT;
      default:        return ftt_pkg::TK_NONE;
    endcase
  endfunction

  function automatic ftt_pkg::token_kind_e control_token(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    // fold lower case letters onto upper case
    if (c >= ChLowerA && c <= ChLowerZ) begin
      u = c & ~CaseBit;
    end
    case (u)
      ChI:     return ftt_pkg::TK_INPUT;
      ChO:     return ftt_pkg::TK_OUTPUT;
      ChC:     return ftt_pkg::TK_CLASS;
      ChE:     return ftt_pkg::TK_IN_DIM;
      ChA:     return ftt_pkg::TK_OUT_DIM;
      ChN:     return ftt_pkg::TK_NUM_PATTERNS;
      default: return ftt_pkg::TK_NONE;
    endcase
  endfunction

  // after a percent sign these land in the string; a zero byte does not
  function automatic bit escapable(input logic [7:0] c);
    return c == ftt_pkg::ChPercent ||
           (c != ftt_pkg::ChNul && punct_kind(c) != ftt_pkg::TK_NONE);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == ftt_pkg::ChSpace || (c >= ftt_pkg::ChTab && c <= ftt_pkg::ChCr);
  endfunction

  function automatic void emit(input ftt_pkg::token_kind_e k, input logic [7:0] v);
    pred_kind[pred_n] = k;
    pred_val[pred_n]  = v;
    pred_n++;
  endfunction

  // string char, then string end once the chunk is full (a zero limit counts as one)
  function automatic void take_string_char(input logic [7:0] c);
    emit(ftt_pkg::TK_STRING_CHAR, c);
    in_string  = 1'b1;
    string_len = string_len + 8'd1;
    if (string_len >= ((chunk_limit == 8'd0) ? 8'd1 : chunk_limit)) begin
      emit(ftt_pkg::TK_STRING_END, 8'd0);
      in_string  = 1'b0;
      string_len = 8'd0;
    end
  endfunction

  function automatic void close_string_then(input ftt_pkg::token_kind_e k);
    if (in_string) begin
      emit(ftt_pkg::TK_STRING_END, 8'd0);
    end
    in_string  = 1'b0;
    string_len = 8'd0;
    emit(k, 8'd0);
  endfunction

  // tokens caused by one accepted char, left in pred_kind / pred_val
  function automatic void tokenize_char(input logic [7:0] c);
    pred_n = 0;
    if (after_percent) begin
      after_percent = 1'b0;
      if (escapable(c)) begin
        take_string_char(c);
      end else if (control_token(c) != ftt_pkg::TK_NONE) begin
        close_string_then(control_token(c));
      end else begin
        // unknown control drops the open string with no string end
        in_string  = 1'b0;
        string_len = 8'd0;
        emit(ftt_pkg::TK_UNKNOWN, c);
      end
    end else if (c == ftt_pkg::ChPercent) begin
      after_percent = 1'b1;
    end else if (punct_kind(c) != ftt_pkg::TK_NONE) begin
      close_string_then(punct_kind(c));
    end else if (!(!in_string && is_blank(c))) begin
      // leading blanks are dropped, everything else joins the string
      take_string_char(c);
    end
  endfunction

  function automatic void owe(input ftt_pkg::token_kind_e k, input logic [7:0] v,
                              input logic l);
    token_t t;
    t.kind = k;
    t.val  = v;
    t.last = l;
    tokens_due.push_back(t);
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------- monitor
  // samples both handshakes and the config port at the rising edge
  always @(posedge clk_i) begin : monitor
    text_row_t row;
    token_t    want;
    bit        moved;
    bit        use_row;
    if (!rst_ni) begin
      chunk_limit   = ftt_pkg::LimitReset;
      after_percent = 1'b0;
      in_string     = 1'b0;
      string_len    = 8'd0;
      idle_cycles   = 0;
    end else begin
      moved = 1'b0;
      if (cfg_we) begin
        chunk_limit = cfg_wdata;
      end
      // accepted char: the predictor always advances, a typed row overrides its answer
      if (push && !full) begin
        moved   = 1'b1;
        use_row = 1'b0;
        tokenize_char(char_code);
        if (typed_answers.size() != 0) begin
          row     = typed_answers.pop_front();
          use_row = row.typed;
        end
        if (use_row) begin
          if (row.n != 2'd0) begin
            owe(row.k0, row.v0, row.n == 2'd1);
          end
          if (row.n == 2'd2) begin
            owe(row.k1, 8'd0, 1'b1);
          end
        end else begin
          for (int i = 0; i < pred_n; i++) begin
            owe(pred_kind[i], pred_val[i], i == pred_n - 1);
          end
        end
      end
      // accepted token: compare with the oldest one owed
      if (pop && !empty) begin
        moved = 1'b1;
        if (tokens_due.size() == 0) begin
          errors++;
          $display("%0t: token with none expected, actual kind %0d value %0d last %0b",
                   $time, token_kind, char_value, last_of_run);
        end else begin
          want = tokens_due.pop_front();
          check_field("token kind", 8'(want.kind), 8'(token_kind));
          check_field("char value", want.val, char_value);
          check_field("last of run", 8'(want.last), 8'(last_of_run));
        end
      end
      // watchdog on cycles with no item moving either way
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("format_text_tokenizer_unit verification failed");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // mostly back to back, some short gaps, a few long ones
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LongHold;
      end
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        hold = pause_len();
        if (hold == 0) begin
          pop <= 1'b1;
        end else begin
          pop <= 1'b0;
          hold--;
        end
      end
    end
  end

  // offer one char after a random gap, return at the edge that takes it
  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = pause_len();
    if (gap != 0) begin
      @(negedge clk_i);
      push      <= 1'b0;
      char_code <= 8'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push      <= 1'b1;
    char_code <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    chars_sent++;
  endtask

  // stop offering and wait for every owed token
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (tokens_due.size() != 0) @(negedge clk_i);
  endtask

  // limit writes only with the block idle; a percent sign leaves no token to wait on
  task automatic write_limit(input logic [7:0] v);
    drain();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic void add_char(input logic [7:0] c);
    text_row_t r;
    r        = '0;
    r.value  = c;
    directed_text.push_back(r);
  endfunction

  function automatic void add_known(input logic [7:0] c, input logic [1:0] n,
                                    input ftt_pkg::token_kind_e k0, input logic [7:0] v0,
                                    input ftt_pkg::token_kind_e k1);
    text_row_t r;
    r       = '0;
    r.value = c;
    r.typed = 1'b1;
    r.n     = n;
    r.k0    = k0;
    r.v0    = v0;
    r.k1    = k1;
    directed_text.push_back(r);
  endfunction

  function automatic void add_limit(input logic [7:0] v);
    text_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.value  = v;
    directed_text.push_back(r);
  endfunction

  // ---------------------------------------------------------------- random text

  function automatic logic [7:0] punct_at(input int i);
    case (i)
      0:       return ChLBracket;
      1:       return ChRBracket;
      2:       return ChLBrace;
      3:       return ChRBrace;
      4:       return ChBar;
      5:       return ChStar;
      6:       return ChQuest;
      7:       return ChLess;
      8:       return ChBslash;
      default: return ftt_pkg::ChNul;
    endcase
  endfunction

  // any byte that is neither percent, structural nor end of text
  function automatic logic [7:0] literal_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == ftt_pkg::ChPercent || punct_kind(c) != ftt_pkg::TK_NONE);
    return c;
  endfunction

  function automatic logic [7:0] control_letter();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0:       c = ChI;
      1:       c = ChO;
      2:       c = ChC;
      3:       c = ChE;
      4:       c = ChA;
      default: c = ChN;
    endcase
    return $urandom_range(0, 1) ? (c | CaseBit) : c;
  endfunction

  function automatic logic [7:0] blank_char();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? ftt_pkg::ChSpace : ftt_pkg::ChTab + 8'(r);
  endfunction

  // one well-formed piece of format text, or now and then a random byte
  task automatic send_fragment();
    int r;
    int k;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      repeat ($urandom_range(1, 12)) send_char(literal_char());
    end else if (r < 50) begin
      send_char(ftt_pkg::ChPercent);
      send_char(control_letter());
    end else if (r < 64) begin
      send_char(punct_at($urandom_range(0, 9)));
    end else if (r < 72) begin
      // escape: percent sign or a structural char other than end of text
      k = $urandom_range(0, 9);
      send_char(ftt_pkg::ChPercent);
      send_char((k == 9) ? ftt_pkg::ChPercent : punct_at(k));
    end else if (r < 77) begin
      do begin
        c = 8'($urandom);
      end while (escapable(c) || control_token(c) != ftt_pkg::TK_NONE);
      send_char(ftt_pkg::ChPercent);
      send_char(c);
    end else if (r < 84) begin
      repeat ($urandom_range(1, 3)) send_char(blank_char());
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    text_row_t  row;
    logic [7:0] limits [8];
    int         phase_start;
    bit         paused;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed text, limit 255 from reset
    add_known(ftt_pkg::ChNul, 2'd1, ftt_pkg::TK_END_OF_TEXT, 8'd0, ftt_pkg::TK_NONE);
    add_known(ftt_pkg::ChSpace, 2'd0, ftt_pkg::TK_NONE, 8'd0,
              ftt_pkg::TK_NONE);                              // leading blank dropped
    add_known(8'hff, 2'd1, ftt_pkg::TK_STRING_CHAR, 8'hff, ftt_pkg::TK_NONE);
    add_char(ftt_pkg::ChCr);                                  // blank inside a string is kept
    add_known(ChLBracket, 2'd2, ftt_pkg::TK_STRING_END, 8'd0, ftt_pkg::TK_ALT_BEGIN);
    add_known(ChRBracket, 2'd1, ftt_pkg::TK_ALT_END, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChLBrace, 2'd1, ftt_pkg::TK_LOOP_BEGIN, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChRBrace, 2'd1, ftt_pkg::TK_LOOP_END, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChBar, 2'd1, ftt_pkg::TK_BAR, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChStar, 2'd1, ftt_pkg::TK_ASTERISK, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChQuest, 2'd1, ftt_pkg::TK_QUESTION, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChLess, 2'd1, ftt_pkg::TK_NEWLINE, 8'd0, ftt_pkg::TK_NONE);
    add_known(ChBslash, 2'd1, ftt_pkg::TK_WRITE_NEWLINE, 8'd0, ftt_pkg::TK_NONE);
    add_char(8'h5a);
    add_char(ftt_pkg::ChPercent);
    add_char(ChI | CaseBit);
    add_char(ftt_pkg::ChPercent);
    add_char(ChO);
    add_char(ftt_pkg::ChPercent);
    add_char(ChC | CaseBit);
    add_char(ftt_pkg::ChPercent);
    add_char(ChE);
    add_char(ftt_pkg::ChPercent);
    add_char(ChA | CaseBit);
    add_char(ftt_pkg::ChPercent);
    add_char(ChN);
    // escaped percent opens a string, then an unknown control abandons it
    add_char(ftt_pkg::ChPercent);
    add_char(ftt_pkg::ChPercent);
    add_char(ftt_pkg::ChPercent);
    add_known(8'h78, 2'd1, ftt_pkg::TK_UNKNOWN, 8'h78, ftt_pkg::TK_NONE);
    add_char(ftt_pkg::ChPercent);
    add_known(ftt_pkg::ChNul, 2'd1, ftt_pkg::TK_UNKNOWN, 8'h00, ftt_pkg::TK_NONE);
    // chunk limit of one, then a zero limit written below the open count
    add_limit(8'd1);
    add_known(8'h62, 2'd2, ftt_pkg::TK_STRING_CHAR, 8'h62, ftt_pkg::TK_STRING_END);
    add_limit(8'd255);
    add_char(8'h63);
    add_limit(8'd0);
    add_char(8'h64);

    foreach (directed_text[i]) begin
      row = directed_text[i];
      if (row.is_cfg) begin
        write_limit(row.value);
      end else begin
        typed_answers.push_back(row);
        send_char(row.value);
      end
    end

    // random text in phases, one chunk limit each
    limits[0] = 8'd255;
    limits[1] = 8'd1;
    limits[2] = 8'd0;
    limits[3] = 8'd3;
    limits[4] = 8'd255;
    limits[5] = 8'($urandom_range(1, 254));
    limits[6] = 8'd7;
    limits[7] = 8'($urandom_range(2, 20));

    foreach (limits[p]) begin
      write_limit(limits[p]);
      phase_start = chars_sent;
      paused      = 1'b0;
      calm        = (p == 2);
      if (p == 4) begin
        // one string well past the 255 char chunk
        send_char(literal_char() | 8'h80);
        repeat (259) send_char(literal_char());
      end
      if (p == 5) begin
        // receiver holds off while chars keep coming, so the queue fills and full rises
        calm          = 1'b1;
        long_hold_req = 1'b1;
        repeat (24) send_char(literal_char());
        calm          = 1'b0;
      end
      while (chars_sent - phase_start < PhaseChars) begin
        // halfway through, the sender waits for every owed token
        if (!paused && chars_sent - phase_start >= PhaseChars / 2) begin
          drain();
          paused = 1'b1;
        end
        send_fragment();
      end
    end
    calm = 1'b0;

    drain();
    repeat (SettleCycles * 3) @(negedge clk_i);
    if (errors == 0 && tokens_due.size() == 0) begin
      $display("format_text_tokenizer_unit verification clean");
    end else begin
      $display("format_text_tokenizer_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ftt_pkg.sv
hdl/ftt_front.sv
hdl/ftt_queue.sv
hdl/ftt_back.sv
hdl/format_text_tokenizer_unit.sv
test/format_text_tokenizer_unit_test.sv
